@@ hw/rtl/ffsa_pkg.sv @@
// Shared types and constants of the first-fit segment allocator.
package ffsa_pkg;

  localparam int AMT_W      = 16;  // segment size / request width
  localparam int POS_W      = 4;   // reported position width
  localparam int CNT_W      = 5;   // reported segment count width
  localparam int IN_DATA_W  = 24;  // amount + used_flag, padded to bytes
  localparam int IN_USER_W  = 1;   // action
  localparam int OUT_DATA_W = 16;  // position + segment_count, padded
  localparam int OUT_USER_W = 2;   // status

  localparam logic ACT_PUSH  = 1'b0;
  localparam logic ACT_ALLOC = 1'b1;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_NOFIT = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    logic             used;
    logic [AMT_W-1:0] size;
  } seg_entry_t;

  localparam int ENTRY_W = $bits(seg_entry_t);

endpackage

@@ hw/rtl/ffsa_ram.sv @@
// Generic simple dual-port RAM, one write and one registered read port.
module ffsa_ram #(
  parameter int WIDTH = 17,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hw/rtl/first_fit_segment_allocator_core.sv @@
// Top level of the first-fit segment allocator: sequencer around the table RAM.
//
// Usage
//   Input words arrive on s_axis: tuser is the action (0 push a segment at
//   the front, 1 allocate), tdata carries amount and used_flag. Each word
//   gives exactly one result word on m_axis: tuser is the status (done, no
//   fit, table full), tdata carries the granted position and the number of
//   segments held afterwards.
//   The segment table sits in one RAM, one entry per segment, kept in order.
//   Items are handled one at a time. A push moves each held entry one place
//   back (one entry per cycle) and then writes the new entry at the front. An
//   allocate scans one entry per cycle up to the first fit; a split then moves
//   the later entries back, writes the remainder and marks the fit used.
//   Exact fits are marked used in place; a miss or refusal goes straight to
//   the result. The single RAM write port and the one-entry-per-cycle scan set this pace.
//   Results are held in an output register; the next word is accepted while
//   a result still waits, and only the completion of that next item stalls
//   until m_axis_tready takes the earlier result.
//   Reset (rst, synchronous) empties the table and drops any pending result;
//   RAM contents are not cleared, entries are only read after being written.
module first_fit_segment_allocator_core #(
  parameter int MAX_SEGMENTS = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // [15:0] amount, [16] used_flag, [23:17] zero
  input  logic [ffsa_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  // [0] action
  input  logic [ffsa_pkg::IN_USER_W-1:0]   s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // [3:0] position, [8:4] segment_count, [15:9] zero
  output logic [ffsa_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
  // [1:0] status
  output logic [ffsa_pkg::OUT_USER_W-1:0]  m_axis_tuser
);

  import ffsa_pkg::*;

  localparam int AW = $clog2(MAX_SEGMENTS);
  localparam int CW = $clog2(MAX_SEGMENTS + 1);
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_SEGMENTS);

  typedef enum logic [2:0] {
    IDLE,
    SCAN,
    SHIFT,
    SHIFT_END,
    INSERT,
    WRITE_HIT,
    RESULT
  } state_t;

  state_t            state;
  logic [CW-1:0]     total;
  logic              is_alloc;
  logic [AMT_W-1:0]  amount_q;

  // scan pipeline: one read issued, previous one checked, per cycle
  logic [AW-1:0]     scan_idx;
  logic              chk_valid;
  logic [AW-1:0]     chk_idx;

  // shift sweep: read rd_idx, write it one place back next cycle
  logic [AW-1:0]     rd_idx;
  logic [AW-1:0]     lo_idx;
  logic              pend_valid;
  logic [AW-1:0]     pend_addr;

  logic [AW-1:0]     ins_addr;
  seg_entry_t        ins_entry;

  status_t           res_status;
  logic [AW-1:0]     res_pos;

  status_t           out_status;
  logic [POS_W-1:0]  out_pos;
  logic [CNT_W-1:0]  out_count;

  // RAM ports
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  seg_entry_t        ram_wdata;
  logic [AW-1:0]     ram_raddr;
  seg_entry_t        ram_rdata;

  logic              hit;
  logic              exact;
  logic              chk_last;

  ffsa_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_SEGMENTS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign s_axis_tready = (state == IDLE);

  assign hit      = chk_valid && !ram_rdata.used && (ram_rdata.size >= amount_q);
  assign exact    = (ram_rdata.size == amount_q);
  assign chk_last = (CW'(chk_idx) + 1'b1) == total;

  // read address follows the active sweep; write port serves the shift
  // first, then the final entry writes
  always_comb begin
    ram_raddr = (state == SCAN) ? scan_idx : rd_idx;
    ram_we    = 1'b0;
    ram_waddr = pend_addr;
    ram_wdata = ram_rdata;
    if (pend_valid) begin
      ram_we = 1'b1;
    end else if (state == INSERT) begin
      ram_we    = 1'b1;
      ram_waddr = ins_addr;
      ram_wdata = ins_entry;
    end else if (state == WRITE_HIT) begin
      ram_we         = 1'b1;
      ram_waddr      = res_pos;
      ram_wdata.used = 1'b1;
      ram_wdata.size = amount_q;
    end else if ((state == SCAN) && hit && exact) begin
      ram_we         = 1'b1;
      ram_waddr      = chk_idx;
      ram_wdata.used = 1'b1;
      ram_wdata.size = ram_rdata.size;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= IDLE;
      total         <= '0;
      chk_valid     <= 1'b0;
      pend_valid    <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      // in RESULT the handshake is handled by the publish step below
      if (m_axis_tvalid && m_axis_tready && (state != RESULT)) begin
        m_axis_tvalid <= 1'b0;
      end

      case (state)
        IDLE: begin
          if (s_axis_tvalid) begin
            amount_q   <= s_axis_tdata[AMT_W-1:0];
            is_alloc   <= s_axis_tuser[0];
            res_pos    <= '0;
            rd_idx     <= AW'(total - 1'b1);
            if (s_axis_tuser[0] == ACT_PUSH) begin
              ins_addr       <= '0;
              ins_entry.used <= s_axis_tdata[AMT_W];
              ins_entry.size <= s_axis_tdata[AMT_W-1:0];
              lo_idx         <= '0;
              if (total == MAX_CNT) begin
                res_status <= ST_FULL;
                state      <= RESULT;
              end else if (total == '0) begin
                res_status <= ST_DONE;
                state      <= INSERT;
              end else begin
                res_status <= ST_DONE;
                state      <= SHIFT;
              end
            end else begin
              scan_idx  <= '0;
              chk_valid <= 1'b0;
              if (total == '0) begin
                res_status <= ST_NOFIT;
                state      <= RESULT;
              end else begin
                res_status <= ST_DONE;
                state      <= SCAN;
              end
            end
          end
        end

        SCAN: begin
          if (hit) begin
            chk_valid <= 1'b0;
            if (exact) begin
              res_pos <= chk_idx;
              state   <= RESULT;
            end else if (total == MAX_CNT) begin
              // split needs a new entry; leave the table as it is
              res_status <= ST_FULL;
              state      <= RESULT;
            end else begin
              res_pos        <= chk_idx;
              ins_addr       <= chk_idx + 1'b1;
              ins_entry.used <= 1'b0;
              ins_entry.size <= ram_rdata.size - amount_q;
              lo_idx         <= chk_idx + 1'b1;
              rd_idx         <= AW'(total - 1'b1);
              state          <= chk_last ? INSERT : SHIFT;
            end
          end else if (chk_valid && chk_last) begin
            chk_valid  <= 1'b0;
            res_status <= ST_NOFIT;
            state      <= RESULT;
          end else begin
            chk_valid <= 1'b1;
            chk_idx   <= scan_idx;
            scan_idx  <= scan_idx + 1'b1;
          end
        end

        SHIFT: begin
          pend_valid <= 1'b1;
          pend_addr  <= rd_idx + 1'b1;
          if (rd_idx == lo_idx) begin
            state <= SHIFT_END;
          end else begin
            rd_idx <= rd_idx - 1'b1;
          end
        end

        SHIFT_END: begin
          // last moved entry is written this cycle
          pend_valid <= 1'b0;
          state      <= INSERT;
        end

        INSERT: begin
          total <= total + 1'b1;
          state <= is_alloc ? WRITE_HIT : RESULT;
        end

        WRITE_HIT: begin
          state <= RESULT;
        end

        RESULT: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tvalid <= 1'b1;
            out_status    <= res_status;
            out_pos       <= POS_W'(res_pos);
            out_count     <= CNT_W'(total);
            state         <= IDLE;
          end
        end

        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

  assign m_axis_tuser = out_status;
  assign m_axis_tdata = {{(OUT_DATA_W - POS_W - CNT_W){1'b0}}, out_count, out_pos};

  // table never grows past its capacity
  a_total_bound: assert property (@(posedge clk) disable iff (rst)
    total <= MAX_CNT)
    else $error("segment count above capacity");

  // the count only ever grows by one, and only on the insert step
  a_total_step: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && (total != $past(total)) |->
      (total == $past(total) + 1'b1) && ($past(state) == INSERT))
    else $error("segment count changed outside insert");

  // a shift write never lands on the entry being read
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    pend_valid |-> ram_waddr != ram_raddr)
    else $error("shift write collides with read");

  // refusals report position zero
  a_refuse_pos: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (out_status != ST_DONE) |-> out_pos == '0)
    else $error("refusal with non-zero position");

  // items enter only from idle with no shift write left over
  a_idle_clean: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |-> !pend_valid && !chk_valid)
    else $error("item accepted with sweep still active");

endmodule
